// ===== rtl/sqwc_pkg.sv =====
package sqwc_pkg;

  localparam int InWidth  = 24;
  localparam int OutWidth = 16;

  typedef enum logic [2:0] {
    MODE_WRITE    = 3'd0,
    MODE_READ     = 3'd1,
    MODE_ADVANCE  = 3'd2,
    MODE_LENGTH   = 3'd3,
    MODE_ENVELOPE = 3'd4,
    MODE_SWEEP    = 3'd5
  } mode_t;

  localparam logic [2:0] RegSweep  = 3'd0;
  localparam logic [2:0] RegLength = 3'd1;
  localparam logic [2:0] RegEnv    = 3'd2;
  localparam logic [2:0] RegLow    = 3'd3;
  localparam logic [2:0] RegHigh   = 3'd4;

  localparam logic [10:0] PeriodMax = 11'd2047;

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    unique case (sel)
      2'd0: pat = 8'h80;
      2'd1: pat = 8'h81;
      2'd2: pat = 8'hE1;
      default: pat = 8'h7E;
    endcase
    return pat[3'd7 - pos];
  endfunction

  function automatic logic [13:0] reload_of(input logic [10:0] p);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, p};
    return {d, 2'b00};
  endfunction

endpackage

// ===== rtl/square_wave_channel_sweep_envelope.sv =====
// Writes, reads and ticks go from ST_IDLE to ST_DONE, via ST_FIRE2 or ST_SWEEP2 when a
// trigger or sweep update must check the new period for overflow. An advance with the
// channel on passes through ST_ADV, which wraps the period timer until it is positive,
// one wrap per cycle, reusing one timer adder; with the channel off it goes to ST_DONE.
// One item in flight: a new item is taken only in ST_IDLE with no result pending.
// Reset (rst, synchronous) clears the control and channel state and sets the sweep enable.
module square_wave_channel_sweep_envelope (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic                            cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mode[2:0], reg_index[5:3], write_value[13:6], cycles[21:14], zero[23:22]
  input  logic [sqwc_pkg::InWidth-1:0]    s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // read_data[7:0], sample[11:8], channel_on[12], zero[15:13]
  output logic [sqwc_pkg::OutWidth-1:0]   m_tdata
);
  import sqwc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADV, ST_SWEEP2, ST_FIRE2, ST_DONE
  } state_t;

  state_t      state;
  state_t      idle_next;
  logic        sweep_en;
  logic [7:0]  reg_copy [5];
  logic        channel_active, dac_on, sweep_down, sweep_active, length_on, env_up;
  logic [10:0] period_value, shadow_period;
  logic [14:0] period_timer;
  logic [2:0]  duty_position, sweep_period, sweep_shift, env_period;
  logic [1:0]  duty_select;
  logic [3:0]  sweep_counter, env_counter, env_start_volume, volume;
  logic [6:0]  length_count;
  logic [7:0]  read_hold;
  logic [7:0]  read_value;
  logic signed [15:0] t_acc;

  logic [2:0]  in_mode, in_idx;
  logic [7:0]  in_wv, in_cyc;
  logic        accept;
  logic [10:0] shift_d;
  logic [11:0] sweep_next;
  logic [10:0] pv_write;
  logic [3:0]  swc_dec, envc_dec;
  logic [6:0]  len_dec;
  logic signed [15:0] t_sum;

  assign in_mode = s_tdata[2:0];
  assign in_idx  = s_tdata[5:3];
  assign in_wv   = s_tdata[13:6];
  assign in_cyc  = s_tdata[21:14];
  assign accept  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  assign shift_d    = shadow_period >> sweep_shift;
  assign sweep_next = sweep_down ? ({1'b0, shadow_period} - {1'b0, shift_d})
                                 : ({1'b0, shadow_period} + {1'b0, shift_d});
  assign pv_write   = {in_wv[2:0], period_value[7:0]};
  assign swc_dec    = (sweep_counter != 4'd0) ? sweep_counter - 4'd1 : 4'd0;
  assign envc_dec   = (env_counter != 4'd0) ? env_counter - 4'd1 : 4'd0;
  assign len_dec    = (length_count != 7'd0) ? length_count - 7'd1 : 7'd0;
  assign t_sum      = t_acc + $signed({2'b00, reload_of(period_value)});

  always_comb begin
    read_value = 8'd0;
    if (in_mode == MODE_READ) begin
      priority case (in_idx)
        RegSweep:  read_value = reg_copy[0] | 8'h80;
        RegLength: read_value = reg_copy[1] | 8'h3F;
        RegEnv:    read_value = reg_copy[2];
        RegHigh:   read_value = reg_copy[4] | 8'hBF;
        default:   read_value = 8'hFF;
      endcase
    end
  end

  always_comb begin
    idle_next = ST_DONE;
    if (in_mode == MODE_ADVANCE && channel_active) begin
      idle_next = ST_ADV;
    end else if (in_mode == MODE_WRITE && in_idx == RegHigh && in_wv[7] && sweep_en &&
                 sweep_shift != 3'd0) begin
      idle_next = ST_FIRE2;
    end else if (in_mode == MODE_SWEEP && sweep_en && swc_dec == 4'd0 && sweep_active &&
                 sweep_period != 3'd0 && sweep_next <= {1'b0, PeriodMax} &&
                 sweep_shift != 3'd0) begin
      idle_next = ST_SWEEP2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      sweep_en <= 1'b1;
      for (int i = 0; i < 5; i++) reg_copy[i] <= 8'd0;
      channel_active <= 1'b0; dac_on <= 1'b0; sweep_down <= 1'b0;
      sweep_active <= 1'b0; length_on <= 1'b0; env_up <= 1'b0;
      period_value <= 11'd0; shadow_period <= 11'd0; period_timer <= 15'd0;
      duty_position <= 3'd0; duty_select <= 2'd0; sweep_period <= 3'd0;
      sweep_shift <= 3'd0; sweep_counter <= 4'd0; length_count <= 7'd0;
      env_period <= 3'd0; env_start_volume <= 4'd0; env_counter <= 4'd0;
      volume <= 4'd0;
    end else begin
      if (cfg_wen) sweep_en <= cfg_wdata;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            read_hold <= read_value;
            state <= idle_next;
            priority case (in_mode)
              MODE_WRITE: begin
                if (in_idx <= RegHigh && !(in_idx == RegSweep && !sweep_en)) begin
                  reg_copy[in_idx] <= in_wv;
                  priority case (in_idx)
                    RegSweep: begin
                      sweep_period <= in_wv[6:4];
                      sweep_down <= in_wv[3];
                      sweep_shift <= in_wv[2:0];
                      sweep_active <= (in_wv[6:4] != 3'd0) || (in_wv[2:0] != 3'd0);
                    end
                    RegLength: begin
                      duty_select <= in_wv[7:6];
                      length_count <= 7'd64 - {1'b0, in_wv[5:0]};
                    end
                    RegEnv: begin
                      env_start_volume <= in_wv[7:4];
                      env_up <= in_wv[3];
                      env_period <= in_wv[2:0];
                      dac_on <= in_wv[7:3] != 5'd0;
                      if (in_wv[7:3] == 5'd0) channel_active <= 1'b0;
                    end
                    RegLow: period_value <= {period_value[10:8], in_wv};
                    default: begin
                      period_value <= pv_write;
                      length_on <= in_wv[6];
                      if (in_wv[7]) begin
                        channel_active <= dac_on;
                        if (length_count == 7'd0) length_count <= 7'd64;
                        period_timer <= {1'b0, reload_of(pv_write)};
                        env_counter <= (env_period != 3'd0) ? {1'b0, env_period} : 4'd8;
                        volume <= env_start_volume;
                        if (sweep_en) begin
                          shadow_period <= pv_write;
                          sweep_counter <= (sweep_period != 3'd0) ?
                                           {1'b0, sweep_period} : 4'd8;
                          sweep_active <= (sweep_period != 3'd0) || (sweep_shift != 3'd0);
                        end
                      end
                    end
                  endcase
                end
              end
              MODE_READ: ;
              MODE_ADVANCE: begin
                if (channel_active) begin
                  t_acc <= $signed({1'b0, period_timer}) - $signed({8'd0, in_cyc});
                end
              end
              MODE_LENGTH: begin
                if (length_on) begin
                  length_count <= len_dec;
                  if (len_dec == 7'd0) channel_active <= 1'b0;
                end
              end
              MODE_ENVELOPE: begin
                if (env_period != 3'd0) begin
                  if (envc_dec == 4'd0) begin
                    env_counter <= {1'b0, env_period};
                    if (env_up) begin
                      if (volume != 4'd15) volume <= volume + 4'd1;
                    end else if (volume != 4'd0) begin
                      volume <= volume - 4'd1;
                    end
                  end else begin
                    env_counter <= envc_dec;
                  end
                end
              end
              MODE_SWEEP: begin
                if (sweep_en) begin
                  if (swc_dec != 4'd0) begin
                    sweep_counter <= swc_dec;
                  end else begin
                    sweep_counter <= (sweep_period != 3'd0) ? {1'b0, sweep_period} : 4'd8;
                    if (sweep_active && sweep_period != 3'd0) begin
                      if (sweep_next > {1'b0, PeriodMax}) begin
                        channel_active <= 1'b0;
                      end else if (sweep_shift != 3'd0) begin
                        shadow_period <= sweep_next[10:0];
                        period_value <= sweep_next[10:0];
                      end
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_ADV: begin
          if (t_acc <= 16'sd0) begin
            t_acc <= t_sum;
            duty_position <= duty_position + 3'd1;
          end else begin
            period_timer <= t_acc[14:0];
            state <= ST_DONE;
          end
        end
        ST_SWEEP2, ST_FIRE2: begin
          if (sweep_next > {1'b0, PeriodMax}) channel_active <= 1'b0;
          state <= ST_DONE;
        end
        default: begin
          m_tvalid <= 1'b1;
          m_tdata <= {3'd0, channel_active,
                      (channel_active && dac_on && duty_bit(duty_select, duty_position))
                        ? volume : 4'd0,
                      read_hold};
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/sqwc_checker.sv =====
module sqwc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sqwc_pkg::OutWidth-1:0] m_tdata
);
  import sqwc_pkg::*;

  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while result pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after a transfer");

  a_silent_off: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[12]) |-> (m_tdata[11:8] == 4'd0))
    else $error("sample while channel off");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind square_wave_channel_sweep_envelope sqwc_checker u_sqwc_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/sv/square_wave_channel_sweep_envelope_checker.sv =====
module square_wave_channel_sweep_envelope_checker
  import sqwc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic                cfg_wdata,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [InWidth-1:0]  s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutWidth-1:0] m_tdata,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic       channel_on;
    logic [3:0] sample;
    logic [7:0] read_data;
  } chan_result_t;

  chan_result_t expected_q[$];

  logic        sweep_unit;
  logic [7:0]  regs [5];
  logic        active, dac, down, sw_active, len_on, up;
  logic [10:0] period, shadow;
  logic [14:0] timer;
  logic [2:0]  duty_idx, sw_period, sw_shift, env_per;
  logic [1:0]  duty_sel;
  logic [3:0]  sw_count, env_count, env_start, vol;
  logic [6:0]  len_count;

  function automatic logic [14:0] timer_reload(input logic [10:0] p);
    return 15'((2048 - int'(p)) * 4);
  endfunction

  function automatic int swept_period();
    int d;
    d = int'(shadow) >> sw_shift;
    return down ? int'(shadow) - d : int'(shadow) + d;
  endfunction

  function automatic logic pattern_bit(input logic [1:0] sel, input logic [2:0] pos);
    logic [7:0] pat;
    case (sel)
      2'd0: pat = 8'h80;
      2'd1: pat = 8'h81;
      2'd2: pat = 8'hE1;
      default: pat = 8'h7E;
    endcase
    return pat[7 - pos];
  endfunction

  task automatic trigger_channel();
    active = dac;
    if (len_count == 0) len_count = 7'd64;
    timer = timer_reload(period);
    env_count = (env_per != 0) ? 4'(env_per) : 4'd8;
    vol = env_start;
    if (sweep_unit) begin
      shadow = period;
      sw_count = (sw_period != 0) ? 4'(sw_period) : 4'd8;
      sw_active = sw_period != 0 || sw_shift != 0;
      if (sw_shift != 0 && swept_period() > 2047) active = 0;
    end
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [7:0] v);
    if (idx > RegHigh || (idx == RegSweep && !sweep_unit)) return;
    regs[idx] = v;
    case (idx)
      RegSweep: begin
        sw_period = v[6:4];
        down = v[3];
        sw_shift = v[2:0];
        sw_active = sw_period != 0 || sw_shift != 0;
      end
      RegLength: begin
        duty_sel = v[7:6];
        len_count = 7'(64 - int'(v[5:0]));
      end
      RegEnv: begin
        env_start = v[7:4];
        up = v[3];
        env_per = v[2:0];
        dac = (v & 8'hF8) != 0;
        if (!dac) active = 0;
      end
      RegLow: period[7:0] = v;
      default: begin
        period[10:8] = v[2:0];
        len_on = v[6];
        if (v[7]) trigger_channel();
      end
    endcase
  endtask

  task automatic advance_timer(input logic [7:0] cyc);
    int t;
    if (!active) return;
    t = int'(timer) - int'(cyc);
    while (t <= 0) begin
      t += int'(timer_reload(period));
      duty_idx = duty_idx + 3'd1;
    end
    timer = t[14:0];
  endtask

  task automatic run_sweep();
    int n;
    if (!sweep_unit) return;
    if (sw_count > 0) sw_count--;
    if (sw_count != 0) return;
    sw_count = (sw_period != 0) ? 4'(sw_period) : 4'd8;
    if (!sw_active || sw_period == 0) return;
    n = swept_period();
    if (n > 2047) begin
      active = 0;
      return;
    end
    if (sw_shift != 0) begin
      shadow = 11'(n);
      period = 11'(n);
      if (swept_period() > 2047) active = 0;
    end
  endtask

  task automatic predict_channel(input logic [InWidth-1:0] d);
    logic [2:0]   m, idx;
    logic [7:0]   wv, cyc;
    chan_result_t r;
    m = d[2:0];
    idx = d[5:3];
    wv = d[13:6];
    cyc = d[21:14];
    r = '0;
    case (m)
      MODE_WRITE: write_register(idx, wv);
      MODE_READ: begin
        case (idx)
          RegSweep: r.read_data = regs[0] | 8'h80;
          RegLength: r.read_data = regs[1] | 8'h3F;
          RegEnv: r.read_data = regs[2];
          RegHigh: r.read_data = regs[4] | 8'hBF;
          default: r.read_data = 8'hFF;
        endcase
      end
      MODE_ADVANCE: advance_timer(cyc);
      MODE_LENGTH: begin
        if (len_on) begin
          if (len_count > 0) len_count--;
          if (len_count == 0) active = 0;
        end
      end
      MODE_ENVELOPE: begin
        if (env_per != 0) begin
          if (env_count > 0) env_count--;
          if (env_count == 0) begin
            env_count = 4'(env_per);
            if (up) begin
              if (vol < 15) vol++;
            end else if (vol > 0) begin
              vol--;
            end
          end
        end
      end
      MODE_SWEEP: run_sweep();
      default: ;
    endcase
    if (active && dac && pattern_bit(duty_sel, duty_idx)) r.sample = vol;
    r.channel_on = active;
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    chan_result_t got, want;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      {active, dac, down, sw_active, len_on, up} = '0;
      period = '0;
      shadow = '0;
      timer = '0;
      {duty_idx, sw_period, sw_shift, env_per, duty_sel} = '0;
      {sw_count, env_count, env_start, vol, len_count} = '0;
      sweep_unit = 1;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wen) sweep_unit = cfg_wdata;
      if (s_tvalid && s_tready) predict_channel(s_tdata);
      if (m_tvalid && m_tready) begin
        got = m_tdata[12:0];
        if (expected_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t read_data expected %h actual %h", $time, want.read_data,
                     got.read_data);
            fail_count++;
          end
          if (got.sample !== want.sample) begin
            $display("%0t sample expected %h actual %h", $time, want.sample, got.sample);
            fail_count++;
          end
          if (got.channel_on !== want.channel_on) begin
            $display("%0t channel_on expected %b actual %b", $time, want.channel_on,
                     got.channel_on);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== tb/sv/square_wave_channel_sweep_envelope_tb.sv =====
module square_wave_channel_sweep_envelope_tb;
  import sqwc_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_wen;
  logic                cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [InWidth-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutWidth-1:0] m_tdata;
  int                  fail_count;
  int                  pending;
  bit                  rx_calm;

  square_wave_channel_sweep_envelope DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  square_wave_channel_sweep_envelope_checker checker_i (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

  // Unless rx_calm is set, the receiver may stall for a random wait before each result transfer.
  initial begin
    int w;
    m_tready = 0;
    @(posedge clk iff !rst);
    forever begin
      w = rx_calm ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk iff m_tvalid);
    end
  end

  task automatic send_item(input logic [2:0] m, input logic [2:0] idx,
                           input logic [7:0] wv, input logic [7:0] cyc, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 4) : 0;
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    s_tdata <= {2'b00, cyc, wv, idx, m};
    s_tvalid <= 1;
    @(posedge clk iff s_tready);
  endtask

  task automatic set_sweep_unit(input logic v);
    @(posedge clk iff pending == 0);
    repeat (80) @(posedge clk);
    cfg_wen <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  task automatic random_phase(input int count);
    int  k, r;
    bit  gaps;
    logic [2:0] idx;
    for (k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        gaps = $urandom_range(0, 3) != 0;
        rx_calm = !gaps;
      end
      r = $urandom_range(0, 99);
      idx = 3'($urandom_range(0, 4));
      if (r < 25) send_item(MODE_WRITE, idx, 8'($urandom), 8'($urandom), gaps);
      else if (r < 32) send_item(MODE_WRITE, RegHigh, 8'h80 | 8'($urandom), 8'($urandom),
                                 gaps);
      else if (r < 42) send_item(MODE_READ, 3'($urandom_range(0, 7)), 8'($urandom),
                                 8'($urandom), gaps);
      else if (r < 62) send_item(MODE_ADVANCE, 3'($urandom), 8'($urandom), 8'($urandom),
                                 gaps);
      else if (r < 71) send_item(MODE_LENGTH, 3'($urandom), 8'($urandom), 8'($urandom),
                                 gaps);
      else if (r < 80) send_item(MODE_ENVELOPE, 3'($urandom), 8'($urandom), 8'($urandom),
                                 gaps);
      else if (r < 95) send_item(MODE_SWEEP, 3'($urandom), 8'($urandom), 8'($urandom),
                                 gaps);
      else send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 8'($urandom),
                     8'($urandom), gaps);
    end
    s_tvalid <= 0;
    rx_calm = 0;
  endtask

  initial begin
    int i;
    rst = 1;
    cfg_wen = 0;
    cfg_wdata = 0;
    s_tvalid = 0;
    s_tdata = '0;
    rx_calm = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_item(MODE_WRITE, RegSweep, 8'h70, 8'd0, 1'b1);
    send_item(MODE_WRITE, RegLength, 8'hFF, 8'd0, 1'b1);
    send_item(MODE_WRITE, RegEnv, 8'hF7, 8'd0, 1'b1);
    send_item(MODE_WRITE, RegLow, 8'hFF, 8'd0, 1'b1);
    send_item(MODE_WRITE, RegHigh, 8'hC7, 8'd0, 1'b1);
    send_item(MODE_ADVANCE, 3'd0, 8'd0, 8'hFF, 1'b1);
    send_item(MODE_ADVANCE, 3'd0, 8'd0, 8'h00, 1'b1);
    send_item(MODE_LENGTH, 3'd0, 8'd0, 8'd0, 1'b1);
    send_item(MODE_ENVELOPE, 3'd0, 8'd0, 8'd0, 1'b1);
    send_item(MODE_SWEEP, 3'd0, 8'd0, 8'd0, 1'b1);
    for (i = 0; i < 8; i++) send_item(MODE_READ, 3'(i), 8'd0, 8'd0, 1'b1);
    send_item(MODE_WRITE, 3'd7, 8'hFF, 8'd0, 1'b1);
    send_item(3'd6, 3'd0, 8'd0, 8'd0, 1'b1);
    send_item(3'd7, 3'd7, 8'hFF, 8'hFF, 1'b1);
    send_item(MODE_WRITE, RegEnv, 8'h00, 8'd0, 1'b1);
    send_item(MODE_WRITE, RegEnv, 8'h08, 8'd0, 1'b1);
    send_item(MODE_WRITE, RegHigh, 8'h80, 8'd0, 1'b1);

    random_phase(700);
    set_sweep_unit(0);
    random_phase(500);
    set_sweep_unit(1);
    random_phase(700);

    @(posedge clk iff pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
